// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/bmms_pkg.sv -----
package bmms_pkg;

  localparam int NUM_BINS   = 12;
  localparam int COUNT_BITS = 16;
  localparam int BIN_BITS   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  localparam int IDX_W      = 4;
  localparam int PRECIP_W   = 16;
  localparam int TEMP_W     = 12;
  localparam int TOTP_W     = 32;
  localparam int TOTT_W     = 28;
  localparam int OUT_CNT_W  = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 160;

  // Serial divider: one quotient bit per step over a 32-bit dividend.
  localparam int DIV_W      = 32;
  localparam int DIV_STEPS  = DIV_W;
  localparam int STEP_BITS  = $clog2(DIV_STEPS);

  localparam int AVG_T_POS_LIM = 2047;
  localparam int AVG_T_NEG_LIM = 2048;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic        [TOTP_W-1:0]     tot_p;
    logic        [PRECIP_W-1:0]   max_p;
    logic        [PRECIP_W-1:0]   min_p;
    logic signed [TOTT_W-1:0]     tot_t;
    logic signed [TEMP_W-1:0]     max_t;
    logic signed [TEMP_W-1:0]     min_t;
    logic        [COUNT_BITS-1:0] cnt;
  } bin_entry_t;

  typedef struct packed {
    logic load;      // capture the input word
    logic rd;        // read the bin memory
    logic upd;       // update and write back the bin, start the divider
    logic div_step;  // one divider step
    logic out_load;  // load the result register
  } ctl_cmd_t;

  typedef struct packed {
    logic bin_ok;      // bin number is within range
    logic empty_next;  // bin holds no samples after the update
    logic out_free;    // result register can take a new word
  } dp_sts_t;

endpackage

// ----- src/bmms_div.sv -----
module bmms_div
  import bmms_pkg::*;
(
  input  logic                              clk,
  input  logic                              start,
  input  logic                              step,
  input  logic [1:0][DIV_W-1:0]             dividend,
  input  logic [COUNT_BITS-1:0]             divisor,
  output logic [1:0][DIV_W-1:0]             quotient
);

  logic [COUNT_BITS-1:0]      dvs;
  logic [1:0][COUNT_BITS-1:0] rem;
  logic [1:0][DIV_W-1:0]      q;
  logic [1:0][COUNT_BITS-1:0] rem_next;
  logic [1:0][DIV_W-1:0]      q_next;
  logic [1:0][COUNT_BITS:0]   trial;
  logic [1:0][COUNT_BITS:0]   diff;

  // Two restoring lanes share the divisor and the step strobe.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem[l], q[l][DIV_W-1]};
      diff[l]  = trial[l] - {1'b0, dvs};
      if (trial[l] >= {1'b0, dvs}) begin
        rem_next[l] = diff[l][COUNT_BITS-1:0];
        q_next[l]   = {q[l][DIV_W-2:0], 1'b1};
      end else begin
        rem_next[l] = trial[l][COUNT_BITS-1:0];
        q_next[l]   = {q[l][DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      q   <= dividend;
    end else if (step) begin
      rem <= rem_next;
      q   <= q_next;
    end
  end

  assign quotient = q;

endmodule

// ----- src/bmms_datapath.sv -----
module bmms_datapath
  import bmms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd,
  output dp_sts_t               sts,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  in_kind,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [1:0]            out_flags
);

  logic                    cmd_r;
  logic [IDX_W-1:0]        bin_r;
  logic [PRECIP_W-1:0]     p_r;
  logic signed [TEMP_W-1:0] t_r;

  logic [BIN_BITS+IDX_W-1:0] addr_wide;
  logic [BIN_BITS-1:0]       addr;

  bin_entry_t              mem [NUM_BINS];
  logic [NUM_BINS-1:0]     valid;
  bin_entry_t              rd_q;
  logic                    rd_valid_q;

  bin_entry_t              old_e;
  bin_entry_t              upd_e;
  bin_entry_t              nxt;
  bin_entry_t              cur;
  logic                    acc;
  logic                    sat;
  logic                    first;
  logic                    do_write;
  logic [TOTP_W:0]         tp_sum;
  logic signed [TOTT_W:0]  tt_sum;
  logic [TOTT_W-1:0]       t_mag;
  logic                    cur_neg;
  logic                    rej_r;

  logic [1:0][DIV_W-1:0]   div_in;
  logic [1:0][DIV_W-1:0]   quot;

  logic                    res_empty;
  logic                    res_rej;
  logic [PRECIP_W-1:0]     avg_p;
  logic [TEMP_W-1:0]       avg_t;
  logic [OUT_DATA_W-1:0]   res_data;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_kind;
      bin_r <= in_data[IDX_W-1:0];
      p_r   <= in_data[IDX_W+PRECIP_W-1:IDX_W];
      t_r   <= in_data[IDX_W+PRECIP_W+TEMP_W-1:IDX_W+PRECIP_W];
    end
  end

  assign addr_wide  = (BIN_BITS+IDX_W)'(bin_r) - 1'b1;
  assign addr       = addr_wide[BIN_BITS-1:0];
  assign sts.bin_ok = (bin_r != '0) &&
                      ((BIN_BITS+IDX_W)'(bin_r) <= (BIN_BITS+IDX_W)'(NUM_BINS));

  // Bin memory; an entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_q       <= mem[addr];
      rd_valid_q <= valid[addr];
    end
    if (cmd.upd && do_write) begin
      mem[addr] <= upd_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.upd && do_write) begin
      valid[addr] <= 1'b1;
    end
  end

  always_comb begin
    old_e    = rd_valid_q ? rd_q : '0;
    acc      = (cmd_r == CMD_ACCUM);
    sat      = &old_e.cnt;
    first    = (old_e.cnt == '0);
    do_write = acc && !sat;

    tp_sum = {1'b0, old_e.tot_p} + (TOTP_W+1)'(p_r);
    tt_sum = (TOTT_W+1)'(old_e.tot_t) + (TOTT_W+1)'(t_r);

    upd_e = old_e;
    upd_e.tot_p = tp_sum[TOTP_W] ? '1 : tp_sum[TOTP_W-1:0];
    if (tt_sum[TOTT_W] != tt_sum[TOTT_W-1]) begin
      upd_e.tot_t = tt_sum[TOTT_W] ? {1'b1, {(TOTT_W-1){1'b0}}}
                                   : {1'b0, {(TOTT_W-1){1'b1}}};
    end else begin
      upd_e.tot_t = tt_sum[TOTT_W-1:0];
    end
    upd_e.cnt = old_e.cnt + 1'b1;
    if (first) begin
      upd_e.max_p = p_r;
      upd_e.min_p = p_r;
      upd_e.max_t = t_r;
      upd_e.min_t = t_r;
    end else begin
      upd_e.max_p = (p_r > old_e.max_p) ? p_r : old_e.max_p;
      upd_e.min_p = (p_r < old_e.min_p) ? p_r : old_e.min_p;
      upd_e.max_t = (t_r > old_e.max_t) ? t_r : old_e.max_t;
      upd_e.min_t = (t_r < old_e.min_t) ? t_r : old_e.min_t;
    end

    nxt   = do_write ? upd_e : old_e;
    t_mag = nxt.tot_t[TOTT_W-1] ? (~nxt.tot_t + 1'b1) : nxt.tot_t;
  end

  assign sts.empty_next = (nxt.cnt == '0);
  assign div_in[0] = DIV_W'(nxt.tot_p);
  assign div_in[1] = DIV_W'(t_mag);

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      cur     <= nxt;
      cur_neg <= nxt.tot_t[TOTT_W-1];
      rej_r   <= acc && sat;
    end
  end

  bmms_div u_div (
    .clk      (clk),
    .start    (cmd.upd),
    .step     (cmd.div_step),
    .dividend (div_in),
    .divisor  (nxt.cnt),
    .quotient (quot)
  );

  // Clamp the quotients into their fields and restore the sign of the temperature mean.
  always_comb begin
    avg_p = (|quot[0][DIV_W-1:PRECIP_W]) ? '1 : quot[0][PRECIP_W-1:0];
    if (!cur_neg) begin
      avg_t = (quot[1] > DIV_W'(AVG_T_POS_LIM)) ? TEMP_W'(AVG_T_POS_LIM)
                                                 : quot[1][TEMP_W-1:0];
    end else begin
      avg_t = (quot[1] > DIV_W'(AVG_T_NEG_LIM)) ? TEMP_W'(AVG_T_NEG_LIM)
                                                 : (~quot[1][TEMP_W-1:0] + 1'b1);
    end
  end

  always_comb begin
    res_data  = '0;
    res_empty = 1'b1;
    res_rej   = acc;
    if (sts.bin_ok) begin
      res_empty = (cur.cnt == '0);
      res_rej   = rej_r;
      if (res_empty) begin
        res_data = {OUT_CNT_W'(cur.cnt), {(3*TEMP_W){1'b0}}, cur.tot_t,
                    {(3*PRECIP_W){1'b0}}, cur.tot_p};
      end else begin
        res_data = {OUT_CNT_W'(cur.cnt), cur.min_t, cur.max_t, avg_t, cur.tot_t,
                    cur.min_p, cur.max_p, avg_p, cur.tot_p};
      end
    end
  end

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data  <= res_data;
      out_flags <= {res_rej, res_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- src/bmms_ctrl.sv -----
module bmms_ctrl
  import bmms_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [STEP_BITS-1:0] step_cnt;
  logic                 last_step;

  assign last_step = (step_cnt == STEP_BITS'(DIV_STEPS - 1));

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = sts.bin_ok;
        state_next = sts.bin_ok ? ST_UPD : ST_DONE;
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = sts.empty_next ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (cmd.upd) begin
        step_cnt <= '0;
      end else if (cmd.div_step) begin
        step_cnt <= step_cnt + 1'b1;
      end
    end
  end

endmodule

// ----- src/binned_min_max_sum_stats.sv -----
// Per-bin running statistics for a precipitation channel (unsigned hundredths) and a
// temperature channel (signed tenths) over twelve bins numbered from one. Every input
// word produces exactly one output word: an accumulate word adds its two samples to
// the bin first, a read word leaves the bin as it is, and the output describes the
// bin afterwards with totals, extremes, sample count and truncated averages. An empty
// bin reports zero averages and extremes with the empty flag set; a bin whose count
// is saturated refuses the sample and sets the rejected flag; a bin number of zero or
// above twelve reports all zeros with the empty flag (and rejected on accumulate).
// All bins read as zero after reset, with no clearing pass. The block handles one word
// at a time. The output word of an item is valid once the 32-step serial divider has
// formed both averages side by side, and the next input word can be taken once that
// output word is valid. An item that leaves its bin empty skips the divider, and an
// item for an out-of-range bin also skips the memory read and update. A finished word
// waits in the output register while the next input word is accepted; if that word
// is still waiting when the next item is finished, the next item holds in its last
// state until the receiver takes the waiting word.
module binned_min_max_sum_stats
  import bmms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // bin_index[3:0], precip_sample[19:4], temp_sample[31:20]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // cmd[0]: 0 accumulate, 1 read only
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // precip_sum[31:0], avg_precip[47:32], precip_hi[63:48], precip_lo[79:64],
  // temp_sum[107:80], avg_temp[119:108], temp_hi[131:120], temp_lo[143:132],
  // sample_count[159:144]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // bin_empty[0], sample_rejected[1]
  output logic [1:0]            m_tuser
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // The controller sequences memory read, update and write back, the divider
  // steps and the load of the output register.
  bmms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the bin memory, the update logic, the divider and the
  // output register.
  bmms_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_tdata),
    .in_kind   (s_tuser[0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_flags (m_tuser)
  );

endmodule

// ----- src/bmms_checker.sv -----
`include "assert_macros.svh"

module bmms_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [159:0] m_tdata,
  input logic [1:0]   m_tuser,
  input logic         m_tvalid,
  input logic         m_tready
);

  // No output word survives reset.
  `ASSERT_ALWAYS(a_rst_clears_out, rst |=> !m_tvalid, "output valid after reset")

  // A stalled output word holds still.
  `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output word changed")

  // One word at a time: the input side closes right after a word is taken.
  `ASSERT_CLK(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "input accepted while busy")

  // An empty bin reports zero count, averages and extremes.
  `ASSERT_CLK(a_empty_zero, m_tvalid && m_tuser[0] |-> m_tdata[79:32] == '0 && m_tdata[159:108] == '0, "empty bin with nonzero fields")

  // The precipitation mean lies between the extremes.
  `ASSERT_CLK(a_avg_bounds, m_tvalid && !m_tuser[0] |-> m_tdata[79:64] <= m_tdata[47:32] && m_tdata[47:32] <= m_tdata[63:48], "average outside min and max")

endmodule

bind binned_min_max_sum_stats bmms_checker u_bmms_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
